### rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared constants, codes and the CRC-16/CCITT-FALSE byte step for the
// framed packet parser.
// ----------------------------------------------------------------------------
package fpc_pkg;

	localparam int PAYLOAD_MAX_DEF = 256;
	localparam int HDR_BYTES       = 16;
	localparam int CRC_BYTES       = 2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hA5;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;
	localparam logic [7:0] VERSION_RST     = 8'h01;

	// config register indexes
	localparam logic [1:0] REG_SYNC_FIRST     = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND    = 2'd1;
	localparam logic [1:0] REG_FORMAT_VERSION = 2'd2;

	// result status codes
	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_FMT_ERR = 2'd2;
	localparam logic [1:0] ST_CRC_ERR = 2'd3;

	// command codes
	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// header byte positions
	localparam int POS_SYNC2   = 1;
	localparam int POS_VERSION = 2;
	localparam int POS_TYPE    = 3;
	localparam int POS_LEN_LO  = 4;
	localparam int POS_LEN_HI  = 5;
	localparam int POS_SEQ_LO  = 6;
	localparam int POS_SEQ_HI  = 9;
	localparam int POS_TS_LO   = 10;
	localparam int POS_TS_HI   = 13;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/fpc_ram.sv
// ----------------------------------------------------------------------------
// fpc_ram
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module fpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/frame_parser_crc16_core.sv
// ----------------------------------------------------------------------------
// frame_parser_crc16_core
// Byte-serial framed packet receiver with CRC-16/CCITT-FALSE check and a
// two-bank payload buffer that can be read back by index.
//
//  channel | dir | handshake              | contents
//  --------+-----+------------------------+------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | tuser: cmd; tdata: rx_byte, read_index
//  m_*     | out | m_tvalid / m_tready    | tuser: status; tdata: header, read data,
//          |     |                        |   counters
//  cfg_*   | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// One beat per cycle in each direction while the output is not stalled; a result
// passes through the read stage (payload RAM read) and then the output register.
// Parser state and counters update in the cycle the beat is taken.
// Reset clears the control state but not the header capture registers; the payload RAM needs no clearing pass.
// A stalled output holds one result in the output register and one in the
// read stage before s_tready drops.
// ----------------------------------------------------------------------------
module frame_parser_crc16_core #(
	parameter int PAYLOAD_MAX = fpc_pkg::PAYLOAD_MAX_DEF,
	localparam int LEN_W   = $clog2(PAYLOAD_MAX + 1),
	localparam int TDATA_W = ((LEN_W + 176 + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,   // rx_byte[7:0], read_index[15:8]
	input  logic               s_tuser,   // cmd
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // frame_type, frame_length,
	                                      // frame_sequence, frame_timestamp,
	                                      // read_data, format_errors, crc_errors,
	                                      // frames_done, zero fill
	output logic [1:0]         m_tuser,   // status
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	localparam int POS_W = $clog2(PAYLOAD_MAX + fpc_pkg::HDR_BYTES + fpc_pkg::CRC_BYTES + 1);
	localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
	localparam int RAM_AW = IDX_W + 1;

	typedef struct packed {
		logic [1:0]       status;
		logic             rd_ok;
		logic [7:0]       ftype;
		logic [LEN_W-1:0] flen;
		logic [31:0]      fseq;
		logic [31:0]      fts;
		logic [31:0]      fmt_err;
		logic [31:0]      crc_err;
		logic [31:0]      done;
	} res_t;

	// config
	logic [7:0] sync_first_q, sync_second_q, version_q;

	// parser state
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] exp_q, exp_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       ver_q, ver_d;
	logic [7:0]       rx_type_q, rx_type_d;
	logic [15:0]      rx_len_q, rx_len_d;
	logic [31:0]      rx_seq_q, rx_seq_d;
	logic [31:0]      rx_ts_q, rx_ts_d;
	logic [7:0]       crc_lo_q, crc_lo_d;
	logic             bank_q, bank_d;
	logic [7:0]       last_type_q, last_type_d;
	logic [LEN_W-1:0] last_len_q, last_len_d;
	logic [31:0]      last_seq_q, last_seq_d;
	logic [31:0]      last_ts_q, last_ts_d;
	logic [31:0]      fmt_err_q, fmt_err_d;
	logic [31:0]      crc_err_q, crc_err_d;
	logic [31:0]      done_q, done_d;
	logic [1:0]       status_d;
	logic             rd_ok_d;

	// ram
	logic              ram_we, ram_re;
	logic [RAM_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_rdata;

	// pipeline
	logic valid_s1;
	res_t res_s1;
	logic move_s1;
	logic accept;

	logic [7:0]       b;
	logic [7:0]       ridx;
	logic [POS_W:0]   p_plus_crc;
	logic [POS_W-1:0] p_next;
	logic [POS_W-1:0] body_off;

	assign b    = s_tdata[7:0];
	assign ridx = s_tdata[15:8];

	assign cfg_ready = 1'b1;
	assign move_s1   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !valid_s1 || move_s1;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= fpc_pkg::SYNC_FIRST_RST;
			sync_second_q <= fpc_pkg::SYNC_SECOND_RST;
			version_q     <= fpc_pkg::VERSION_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fpc_pkg::REG_SYNC_FIRST:     sync_first_q  <= cfg_data;
				fpc_pkg::REG_SYNC_SECOND:    sync_second_q <= cfg_data;
				fpc_pkg::REG_FORMAT_VERSION: version_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign p_plus_crc = (POS_W + 1)'(pos_q) + (POS_W + 1)'(fpc_pkg::CRC_BYTES);
	assign p_next     = pos_q + POS_W'(1);
	assign body_off   = pos_q - POS_W'(fpc_pkg::HDR_BYTES);

	always_comb begin
		pos_d       = pos_q;
		exp_d       = exp_q;
		crc_d       = crc_q;
		ver_d       = ver_q;
		rx_type_d   = rx_type_q;
		rx_len_d    = rx_len_q;
		rx_seq_d    = rx_seq_q;
		rx_ts_d     = rx_ts_q;
		crc_lo_d    = crc_lo_q;
		bank_d      = bank_q;
		last_type_d = last_type_q;
		last_len_d  = last_len_q;
		last_seq_d  = last_seq_q;
		last_ts_d   = last_ts_q;
		fmt_err_d   = fmt_err_q;
		crc_err_d   = crc_err_q;
		done_d      = done_q;
		status_d    = fpc_pkg::ST_IDLE;
		rd_ok_d     = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = {~bank_q, IDX_W'(body_off)};
		ram_re      = 1'b0;
		ram_raddr   = {bank_q, IDX_W'(ridx)};

		if (accept && s_tuser == fpc_pkg::CMD_READ) begin
			ram_re  = 1'b1;
			rd_ok_d = (16'(ridx) < 16'(last_len_q)) && (16'(ridx) < 16'(PAYLOAD_MAX));
		end else if (accept) begin
			if (pos_q == '0) begin
				if (b == sync_first_q) begin
					crc_d = fpc_pkg::crc_byte(fpc_pkg::CRC_INIT, b);
					pos_d = POS_W'(1);
				end
			end else if (pos_q == POS_W'(fpc_pkg::POS_SYNC2) && b != sync_second_q) begin
				fmt_err_d = fmt_err_q + 32'd1;
				if (b == sync_first_q) begin
					crc_d = fpc_pkg::crc_byte(fpc_pkg::CRC_INIT, b);
					pos_d = POS_W'(1);
				end else begin
					pos_d = '0;
				end
			end else begin
				if (pos_q < POS_W'(fpc_pkg::HDR_BYTES) ||
				    (exp_q != '0 && p_plus_crc < (POS_W + 1)'(exp_q))) begin
					crc_d = fpc_pkg::crc_byte(crc_q, b);
				end

				if (pos_q == POS_W'(fpc_pkg::POS_VERSION)) begin
					ver_d = b;
				end else if (pos_q == POS_W'(fpc_pkg::POS_TYPE)) begin
					rx_type_d = b;
				end else if (pos_q >= POS_W'(fpc_pkg::POS_LEN_LO) &&
				             pos_q <= POS_W'(fpc_pkg::POS_LEN_HI)) begin
					rx_len_d = {b, rx_len_q[15:8]};
				end else if (pos_q >= POS_W'(fpc_pkg::POS_SEQ_LO) &&
				             pos_q <= POS_W'(fpc_pkg::POS_SEQ_HI)) begin
					rx_seq_d = {b, rx_seq_q[31:8]};
				end else if (pos_q >= POS_W'(fpc_pkg::POS_TS_LO) &&
				             pos_q <= POS_W'(fpc_pkg::POS_TS_HI)) begin
					rx_ts_d = {b, rx_ts_q[31:8]};
				end else if (pos_q >= POS_W'(fpc_pkg::HDR_BYTES) && exp_q != '0) begin
					if (16'(body_off) < rx_len_q) begin
						ram_we = 1'b1;
					end else if (p_plus_crc == (POS_W + 1)'(exp_q)) begin
						crc_lo_d = b;
					end
				end

				if (pos_q == POS_W'(fpc_pkg::POS_LEN_HI)) begin
					if (ver_q != version_q || rx_len_d > 16'(PAYLOAD_MAX)) begin
						pos_d     = '0;
						fmt_err_d = fmt_err_q + 32'd1;
						status_d  = fpc_pkg::ST_FMT_ERR;
					end else begin
						pos_d = p_next;
						exp_d = POS_W'(fpc_pkg::HDR_BYTES + fpc_pkg::CRC_BYTES) +
						        POS_W'(rx_len_d);
					end
				end else if (exp_q == '0 || p_next < exp_q) begin
					pos_d = p_next;
				end else begin
					pos_d = '0;
					exp_d = '0;
					if ({b, crc_lo_q} != crc_q) begin
						crc_err_d = crc_err_q + 32'd1;
						status_d  = fpc_pkg::ST_CRC_ERR;
					end else begin
						last_type_d = rx_type_q;
						last_len_d  = LEN_W'(rx_len_q);
						last_seq_d  = rx_seq_q;
						last_ts_d   = rx_ts_q;
						bank_d      = ~bank_q;
						done_d      = done_q + 32'd1;
						status_d    = fpc_pkg::ST_OK;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			exp_q       <= '0;
			crc_q       <= fpc_pkg::CRC_INIT;
			bank_q      <= 1'b0;
			last_type_q <= '0;
			last_len_q  <= '0;
			last_seq_q  <= '0;
			last_ts_q   <= '0;
			fmt_err_q   <= '0;
			crc_err_q   <= '0;
			done_q      <= '0;
		end else begin
			pos_q       <= pos_d;
			exp_q       <= exp_d;
			crc_q       <= crc_d;
			bank_q      <= bank_d;
			last_type_q <= last_type_d;
			last_len_q  <= last_len_d;
			last_seq_q  <= last_seq_d;
			last_ts_q   <= last_ts_d;
			fmt_err_q   <= fmt_err_d;
			crc_err_q   <= crc_err_d;
			done_q      <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		ver_q     <= ver_d;
		rx_type_q <= rx_type_d;
		rx_len_q  <= rx_len_d;
		rx_seq_q  <= rx_seq_d;
		rx_ts_q   <= rx_ts_d;
		crc_lo_q  <= crc_lo_d;
	end

	fpc_ram #(
		.WIDTH (8),
		.DEPTH (2 << IDX_W)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (b),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// read stage: result waits here for the RAM data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.status  <= status_d;
			res_s1.rd_ok   <= rd_ok_d;
			res_s1.ftype   <= last_type_d;
			res_s1.flen    <= last_len_d;
			res_s1.fseq    <= last_seq_d;
			res_s1.fts     <= last_ts_d;
			res_s1.fmt_err <= fmt_err_d;
			res_s1.crc_err <= crc_err_d;
			res_s1.done    <= done_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			m_tuser <= res_s1.status;
			m_tdata <= TDATA_W'({res_s1.done, res_s1.crc_err, res_s1.fmt_err,
			                     res_s1.rd_ok ? ram_rdata : 8'h00,
			                     res_s1.fts, res_s1.fseq, res_s1.flen, res_s1.ftype});
		end
	end

endmodule
